FILE: hw/rtl/bole_pkg.sv
// Package: shared types, codes and constants of the ordered list engine.
package bole_pkg;

    localparam int unsigned CAPACITY_DEF = 32;
    localparam int unsigned DATA_W       = 32;
    localparam int unsigned OPCODE_W     = 4;
    localparam int unsigned POS_W        = 6;
    localparam int unsigned STATUS_W     = 3;

    typedef enum logic [OPCODE_W-1:0] {
        OP_PUSH_FRONT   = 4'd0,
        OP_PUSH_BACK    = 4'd1,
        OP_INSERT_AT    = 4'd2,
        OP_POP_FRONT    = 4'd3,
        OP_POP_BACK     = 4'd4,
        OP_DELETE_AT    = 4'd5,
        OP_DELETE_VALUE = 4'd6,
        OP_DELETE_MAX   = 4'd7,
        OP_FIND         = 4'd8,
        OP_REVERSE      = 4'd9,
        OP_SORT         = 4'd10,
        OP_INSERT_SORT  = 4'd11,
        OP_EVENS_FIRST  = 4'd12
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_BADPOS   = 3'd2,
        ST_FULL     = 3'd3,
        ST_NOTFOUND = 3'd4
    } t_status;

    // Stop rule of the shift-in loop
    typedef enum logic [1:0] {
        CMP_NONE = 2'd0,
        CMP_LE   = 2'd1,
        CMP_LT   = 2'd2
    } t_cmp;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SO_RD,
        S_SO_KEY,
        S_SH_RD,
        S_SH_CK,
        S_CL_RD0,
        S_CL_V,
        S_CL_RD,
        S_CL_WR,
        S_SC_RD,
        S_SC_EV,
        S_RV_RD1,
        S_RV_RD2,
        S_RV_W1,
        S_RV_W2,
        S_FIN
    } t_state;

endpackage

FILE: hw/rtl/bole_if.sv
// Interfaces: command and response channels with valid/ready handshake.
interface bole_cmd_if;
    logic                                valid;
    logic                                ready;
    logic [bole_pkg::OPCODE_W-1:0]       opcode;
    logic signed [bole_pkg::DATA_W-1:0]  value;
    logic [bole_pkg::POS_W-1:0]          position;

    modport source (output valid, opcode, value, position, input ready);
    modport sink   (input valid, opcode, value, position, output ready);
endinterface

interface bole_rsp_if;
    logic                                valid;
    logic                                ready;
    logic signed [bole_pkg::DATA_W-1:0]  value_out;
    logic [bole_pkg::POS_W-1:0]          index_out;
    logic [bole_pkg::STATUS_W-1:0]       status;
    logic [bole_pkg::POS_W-1:0]          count;

    modport source (output valid, value_out, index_out, status, count, input ready);
    modport sink   (input valid, value_out, index_out, status, count, output ready);
endinterface

FILE: hw/rtl/bole_store.sv
// Entry store: one write port, one read port with registered read data.
module bole_store #(
    parameter int unsigned DEPTH = bole_pkg::CAPACITY_DEF,
    parameter int unsigned AW    = $clog2(DEPTH)
) (
    input  logic                               i_clk,
    input  logic                               i_we,
    input  logic [AW-1:0]                      i_waddr,
    input  logic signed [bole_pkg::DATA_W-1:0] i_wdata,
    input  logic [AW-1:0]                      i_raddr,
    output logic signed [bole_pkg::DATA_W-1:0] o_rdata
);

    logic signed [bole_pkg::DATA_W-1:0] r_mem [DEPTH];
    logic signed [bole_pkg::DATA_W-1:0] r_rdata;

    // Write one entry
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Register read data
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/bounded_ordered_list_engine.sv
// Top level: ordered list engine, a sequencer around one entry store and comparator.
//
//  channel | dir | fields                              | accepted when
//  i_cmd   | in  | opcode, value, position             | valid & ready
//  o_rsp   | out | value_out, index_out, status, count | valid & ready
//
// One command at a time; each entry step reads an entry, then compares it
// or writes it, using the store's separate read and write ports.
// Reset empties the list at once; no clearing pass. i_cmd.ready is high in
// idle; a stalled response holds the block in its final state until taken.
module bounded_ordered_list_engine #(
    parameter int unsigned CAPACITY = bole_pkg::CAPACITY_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bole_cmd_if.sink    i_cmd,
    bole_rsp_if.source  o_rsp
);

    localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam int unsigned PW = (CW > bole_pkg::POS_W) ? CW : bole_pkg::POS_W;

    bole_pkg::t_state r_state, n_state;
    bole_pkg::t_op    r_op, n_op;
    bole_pkg::t_cmp   r_cmp, n_cmp;
    logic             r_phase, n_phase;
    logic [CW-1:0]    r_occ, n_occ;
    logic [CW-1:0]    r_i, n_i;
    logic [CW-1:0]    r_j, n_j;
    logic [CW-1:0]    r_k, n_k;
    logic [CW-1:0]    r_lim, n_lim;
    logic [CW-1:0]    r_pos, n_pos;
    logic signed [bole_pkg::DATA_W-1:0] r_val, n_val;
    logic signed [bole_pkg::DATA_W-1:0] r_key, n_key;
    logic signed [bole_pkg::DATA_W-1:0] r_best, n_best;
    logic signed [bole_pkg::DATA_W-1:0] r_vout, n_vout;
    logic [CW-1:0]    r_iout, n_iout;
    bole_pkg::t_status r_st, n_st;

    logic                               r_ovalid, n_ovalid;
    logic signed [bole_pkg::DATA_W-1:0] r_o_value, n_o_value;
    logic [bole_pkg::POS_W-1:0]         r_o_index, n_o_index;
    logic [bole_pkg::STATUS_W-1:0]      r_o_status, n_o_status;
    logic [bole_pkg::POS_W-1:0]         r_o_count, n_o_count;

    logic                               we;
    logic [AW-1:0]                      waddr;
    logic signed [bole_pkg::DATA_W-1:0] wdata;
    logic [AW-1:0]                      raddr;
    logic signed [bole_pkg::DATA_W-1:0] rdata;

    bole_store #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign i_cmd.ready     = (r_state == bole_pkg::S_IDLE);
    assign o_rsp.valid     = r_ovalid;
    assign o_rsp.value_out = r_o_value;
    assign o_rsp.index_out = r_o_index;
    assign o_rsp.status    = r_o_status;
    assign o_rsp.count     = r_o_count;

    // State and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= bole_pkg::S_IDLE;
            r_occ    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_occ    <= n_occ;
            r_ovalid <= n_ovalid;
        end
    end

    // Working and payload registers
    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_cmp      <= n_cmp;
        r_phase    <= n_phase;
        r_i        <= n_i;
        r_j        <= n_j;
        r_k        <= n_k;
        r_lim      <= n_lim;
        r_pos      <= n_pos;
        r_val      <= n_val;
        r_key      <= n_key;
        r_best     <= n_best;
        r_vout     <= n_vout;
        r_iout     <= n_iout;
        r_st       <= n_st;
        r_o_value  <= n_o_value;
        r_o_index  <= n_o_index;
        r_o_status <= n_o_status;
        r_o_count  <= n_o_count;
    end

    // Sequencer: next state, store port and results
    always_comb begin
        logic          sh_fin;
        logic          full;
        logic          stop;
        logic [PW-1:0] pos_w;
        logic [PW-1:0] occ_w;

        n_state    = r_state;
        n_op       = r_op;
        n_cmp      = r_cmp;
        n_phase    = r_phase;
        n_occ      = r_occ;
        n_i        = r_i;
        n_j        = r_j;
        n_k        = r_k;
        n_lim      = r_lim;
        n_pos      = r_pos;
        n_val      = r_val;
        n_key      = r_key;
        n_best     = r_best;
        n_vout     = r_vout;
        n_iout     = r_iout;
        n_st       = r_st;
        n_ovalid   = r_ovalid;
        n_o_value  = r_o_value;
        n_o_index  = r_o_index;
        n_o_status = r_o_status;
        n_o_count  = r_o_count;
        we         = 1'b0;
        waddr      = r_j[AW-1:0];
        wdata      = r_key;
        raddr      = r_i[AW-1:0];
        sh_fin     = 1'b0;
        full       = (r_occ == CW'(CAPACITY));
        stop       = 1'b0;
        pos_w      = PW'(i_cmd.position);
        occ_w      = PW'(r_occ);

        // Drop the response once taken
        if (r_ovalid && o_rsp.ready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            bole_pkg::S_IDLE: begin
                if (i_cmd.valid) begin
                    n_op    = bole_pkg::t_op'(i_cmd.opcode);
                    n_val   = i_cmd.value;
                    n_key   = i_cmd.value;
                    n_vout  = '0;
                    n_iout  = '0;
                    n_st    = bole_pkg::ST_OK;
                    n_phase = 1'b0;
                    n_cmp   = bole_pkg::CMP_NONE;
                    n_i     = '0;
                    n_k     = '0;
                    n_j     = r_occ;
                    n_lim   = '0;
                    n_state = bole_pkg::S_FIN;
                    case (bole_pkg::t_op'(i_cmd.opcode))
                        bole_pkg::OP_PUSH_FRONT: begin
                            if (full) n_st = bole_pkg::ST_FULL;
                            else      n_state = bole_pkg::S_SH_RD;
                        end
                        bole_pkg::OP_PUSH_BACK: begin
                            n_lim = r_occ;
                            if (full) n_st = bole_pkg::ST_FULL;
                            else      n_state = bole_pkg::S_SH_RD;
                        end
                        bole_pkg::OP_INSERT_AT: begin
                            n_lim = CW'(i_cmd.position);
                            if (pos_w > occ_w) n_st = bole_pkg::ST_BADPOS;
                            else if (full)     n_st = bole_pkg::ST_FULL;
                            else               n_state = bole_pkg::S_SH_RD;
                        end
                        bole_pkg::OP_POP_FRONT: begin
                            n_pos = '0;
                            if (r_occ == '0) n_st = bole_pkg::ST_EMPTY;
                            else             n_state = bole_pkg::S_CL_RD0;
                        end
                        bole_pkg::OP_POP_BACK: begin
                            n_pos = r_occ - 1'b1;
                            if (r_occ == '0) n_st = bole_pkg::ST_EMPTY;
                            else             n_state = bole_pkg::S_CL_RD0;
                        end
                        bole_pkg::OP_DELETE_AT: begin
                            n_pos = CW'(i_cmd.position);
                            if (r_occ == '0)         n_st = bole_pkg::ST_EMPTY;
                            else if (pos_w >= occ_w) n_st = bole_pkg::ST_BADPOS;
                            else                     n_state = bole_pkg::S_CL_RD0;
                        end
                        bole_pkg::OP_DELETE_VALUE, bole_pkg::OP_DELETE_MAX: begin
                            if (r_occ == '0) n_st = bole_pkg::ST_EMPTY;
                            else             n_state = bole_pkg::S_SC_RD;
                        end
                        bole_pkg::OP_FIND: begin
                            n_state = bole_pkg::S_SC_RD;
                        end
                        bole_pkg::OP_REVERSE: begin
                            n_j = r_occ - 1'b1;
                            if (r_occ != '0) n_state = bole_pkg::S_RV_RD1;
                        end
                        bole_pkg::OP_SORT: begin
                            n_i     = CW'(1);
                            n_state = bole_pkg::S_SO_RD;
                        end
                        bole_pkg::OP_INSERT_SORT: begin
                            n_i = CW'(1);
                            if (full) n_st = bole_pkg::ST_FULL;
                            else      n_state = bole_pkg::S_SO_RD;
                        end
                        bole_pkg::OP_EVENS_FIRST: begin
                            n_state = bole_pkg::S_SO_RD;
                        end
                        default: begin
                            n_state = bole_pkg::S_FIN;
                        end
                    endcase
                end
            end

            // Outer loop of sort, sorted insert and evens_first: fetch the next key
            bole_pkg::S_SO_RD: begin
                if (r_i >= r_occ) begin
                    if (r_op == bole_pkg::OP_INSERT_SORT) begin
                        n_key   = r_val;
                        n_j     = r_occ;
                        n_lim   = '0;
                        n_cmp   = bole_pkg::CMP_LT;
                        n_phase = 1'b1;
                        n_state = bole_pkg::S_SH_RD;
                    end else begin
                        n_state = bole_pkg::S_FIN;
                    end
                end else begin
                    n_state = bole_pkg::S_SO_KEY;
                end
            end

            bole_pkg::S_SO_KEY: begin
                n_key = rdata;
                n_j   = r_i;
                if (r_op == bole_pkg::OP_EVENS_FIRST) begin
                    if (!rdata[0]) begin
                        n_lim   = r_k;
                        n_cmp   = bole_pkg::CMP_NONE;
                        n_state = bole_pkg::S_SH_RD;
                    end else begin
                        n_i     = r_i + 1'b1;
                        n_state = bole_pkg::S_SO_RD;
                    end
                end else begin
                    n_lim   = '0;
                    n_cmp   = bole_pkg::CMP_LE;
                    n_state = bole_pkg::S_SH_RD;
                end
            end

            // Shift-in loop: move entries up until the key's slot is found
            bole_pkg::S_SH_RD: begin
                raddr = AW'(r_j - 1'b1);
                if (r_j == r_lim) begin
                    we     = 1'b1;
                    sh_fin = 1'b1;
                end else begin
                    n_state = bole_pkg::S_SH_CK;
                end
            end

            bole_pkg::S_SH_CK: begin
                stop = ((r_cmp == bole_pkg::CMP_LE) && (rdata <= r_key)) ||
                       ((r_cmp == bole_pkg::CMP_LT) && (rdata < r_key));
                we = 1'b1;
                if (stop) begin
                    sh_fin = 1'b1;
                end else begin
                    wdata   = rdata;
                    n_j     = r_j - 1'b1;
                    n_state = bole_pkg::S_SH_RD;
                end
            end

            // Close-gap loop: capture the removed value, move entries down
            bole_pkg::S_CL_RD0: begin
                raddr   = r_pos[AW-1:0];
                n_state = bole_pkg::S_CL_V;
            end

            bole_pkg::S_CL_V: begin
                n_vout  = rdata;
                n_i     = r_pos;
                n_state = bole_pkg::S_CL_RD;
            end

            bole_pkg::S_CL_RD: begin
                raddr = AW'(r_i + 1'b1);
                if ((r_i + 1'b1) >= r_occ) begin
                    n_occ   = r_occ - 1'b1;
                    n_state = bole_pkg::S_FIN;
                end else begin
                    n_state = bole_pkg::S_CL_WR;
                end
            end

            bole_pkg::S_CL_WR: begin
                we      = 1'b1;
                waddr   = r_i[AW-1:0];
                wdata   = rdata;
                n_i     = r_i + 1'b1;
                n_state = bole_pkg::S_CL_RD;
            end

            // Linear scan for a value or the first maximum
            bole_pkg::S_SC_RD: begin
                if (r_i >= r_occ) begin
                    if (r_op == bole_pkg::OP_DELETE_MAX) begin
                        n_iout  = r_k;
                        n_pos   = r_k;
                        n_state = bole_pkg::S_CL_RD0;
                    end else begin
                        n_st    = bole_pkg::ST_NOTFOUND;
                        n_state = bole_pkg::S_FIN;
                    end
                end else begin
                    n_state = bole_pkg::S_SC_EV;
                end
            end

            bole_pkg::S_SC_EV: begin
                n_i     = r_i + 1'b1;
                n_state = bole_pkg::S_SC_RD;
                if (r_op == bole_pkg::OP_DELETE_MAX) begin
                    if ((r_i == '0) || (rdata > r_best)) begin
                        n_best = rdata;
                        n_k    = r_i;
                    end
                end else if (rdata == r_val) begin
                    n_iout = r_i;
                    n_pos  = r_i;
                    if (r_op == bole_pkg::OP_FIND) n_state = bole_pkg::S_FIN;
                    else                           n_state = bole_pkg::S_CL_RD0;
                end
            end

            // Reverse: swap the outermost pair and step inward
            bole_pkg::S_RV_RD1: begin
                if (r_i >= r_j) begin
                    n_state = bole_pkg::S_FIN;
                end else begin
                    n_state = bole_pkg::S_RV_RD2;
                end
            end

            bole_pkg::S_RV_RD2: begin
                n_key   = rdata;
                raddr   = r_j[AW-1:0];
                n_state = bole_pkg::S_RV_W1;
            end

            bole_pkg::S_RV_W1: begin
                we      = 1'b1;
                waddr   = r_i[AW-1:0];
                wdata   = rdata;
                n_state = bole_pkg::S_RV_W2;
            end

            bole_pkg::S_RV_W2: begin
                we      = 1'b1;
                n_i     = r_i + 1'b1;
                n_j     = r_j - 1'b1;
                n_state = bole_pkg::S_RV_RD1;
            end

            // Hold until the response register is free, then load it
            bole_pkg::S_FIN: begin
                if (!r_ovalid || o_rsp.ready) begin
                    n_ovalid   = 1'b1;
                    n_o_value  = r_vout;
                    n_o_index  = bole_pkg::POS_W'(r_iout);
                    n_o_status = r_st;
                    n_o_count  = bole_pkg::POS_W'(r_occ);
                    n_state    = bole_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = bole_pkg::S_IDLE;
            end
        endcase

        // Key placed: return to the caller of the shift-in loop
        if (sh_fin) begin
            if (r_op == bole_pkg::OP_EVENS_FIRST) begin
                n_i     = r_i + 1'b1;
                n_k     = r_k + 1'b1;
                n_state = bole_pkg::S_SO_RD;
            end else if ((r_op == bole_pkg::OP_SORT) ||
                         ((r_op == bole_pkg::OP_INSERT_SORT) && !r_phase)) begin
                n_i     = r_i + 1'b1;
                n_state = bole_pkg::S_SO_RD;
            end else begin
                n_occ   = r_occ + 1'b1;
                n_state = bole_pkg::S_FIN;
            end
        end
    end

endmodule

FILE: verif/bounded_ordered_list_engine_tb.sv
// Testbench: ordered list engine checked against a behavioral list predictor.
module bounded_ordered_list_engine_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CAP = 32;
    localparam int unsigned STALL_LIMIT = 20000;

    typedef struct packed {
        logic [bole_pkg::DATA_W-1:0]   vout;
        logic [bole_pkg::POS_W-1:0]    idx;
        logic [bole_pkg::STATUS_W-1:0] st;
        logic [bole_pkg::POS_W-1:0]    cnt;
    } t_rsp;

    typedef struct {
        logic [bole_pkg::OPCODE_W-1:0] op;
        logic [bole_pkg::DATA_W-1:0]   val;
        logic [bole_pkg::POS_W-1:0]    pos;
        bit                            typed;
        t_rsp                          want;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    bole_cmd_if cmd_ch ();
    bole_rsp_if rsp_ch ();

    bounded_ordered_list_engine #(.CAPACITY(CAP)) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (cmd_ch.sink),
        .o_rsp  (rsp_ch.source)
    );

    always #2 i_clk = ~i_clk;

    // Predictor state: the list as a queue, head at index zero
    logic [bole_pkg::DATA_W-1:0] list_q[$];
    t_rsp                        pending_q[$];
    t_row                        typed_q[$];
    int unsigned                 n_fail = 0;
    int unsigned                 quiet = 0;
    int unsigned                 rsp_wait = 0;
    bit                          stim_done = 0;
    t_row                        rows[$];

    task automatic report(input string what);
        $display("mismatch @%0t: %s", $realtime, what);
        n_fail++;
    endtask

    function automatic void sort_list();
        logic [bole_pkg::DATA_W-1:0] key;
        int j;
        for (int i = 1; i < list_q.size(); i++) begin
            key = list_q[i];
            j = i;
            while (j > 0 && $signed(list_q[j-1]) > $signed(key)) begin
                list_q[j] = list_q[j-1];
                j--;
            end
            list_q[j] = key;
        end
    endfunction

    // Apply one command to the list and return the response it should give
    function automatic t_rsp list_apply(input logic [bole_pkg::OPCODE_W-1:0] op,
                                        input logic [bole_pkg::DATA_W-1:0] v,
                                        input logic [bole_pkg::POS_W-1:0] pos);
        t_rsp r;
        int n;
        int k;
        logic [bole_pkg::DATA_W-1:0] ev[$];
        logic [bole_pkg::DATA_W-1:0] od[$];
        bit full;
        r = '0;
        n = list_q.size();
        full = (n >= CAP);
        k = -1;
        case (op)
            bole_pkg::OP_PUSH_FRONT: begin
                if (full) r.st = bole_pkg::ST_FULL; else list_q.push_front(v);
            end
            bole_pkg::OP_PUSH_BACK: begin
                if (full) r.st = bole_pkg::ST_FULL; else list_q.push_back(v);
            end
            bole_pkg::OP_INSERT_AT: begin
                if (pos > n) r.st = bole_pkg::ST_BADPOS;
                else if (full) r.st = bole_pkg::ST_FULL;
                else list_q.insert(pos, v);
            end
            bole_pkg::OP_POP_FRONT: begin
                if (n == 0) r.st = bole_pkg::ST_EMPTY; else r.vout = list_q.pop_front();
            end
            bole_pkg::OP_POP_BACK: begin
                if (n == 0) r.st = bole_pkg::ST_EMPTY; else r.vout = list_q.pop_back();
            end
            bole_pkg::OP_DELETE_AT: begin
                if (n == 0) r.st = bole_pkg::ST_EMPTY;
                else if (pos >= n) r.st = bole_pkg::ST_BADPOS;
                else begin
                    r.vout = list_q[pos];
                    list_q.delete(pos);
                end
            end
            bole_pkg::OP_DELETE_VALUE, bole_pkg::OP_FIND: begin
                for (int i = n - 1; i >= 0; i--) if (list_q[i] == v) k = i;
                if (op == bole_pkg::OP_DELETE_VALUE && n == 0) r.st = bole_pkg::ST_EMPTY;
                else if (k < 0) r.st = bole_pkg::ST_NOTFOUND;
                else begin
                    r.idx = bole_pkg::POS_W'(k);
                    if (op == bole_pkg::OP_DELETE_VALUE) begin
                        r.vout = list_q[k];
                        list_q.delete(k);
                    end
                end
            end
            bole_pkg::OP_DELETE_MAX: begin
                if (n == 0) r.st = bole_pkg::ST_EMPTY;
                else begin
                    k = 0;
                    for (int i = 1; i < n; i++)
                        if ($signed(list_q[i]) > $signed(list_q[k])) k = i;
                    r.idx = bole_pkg::POS_W'(k);
                    r.vout = list_q[k];
                    list_q.delete(k);
                end
            end
            bole_pkg::OP_REVERSE: list_q.reverse();
            bole_pkg::OP_SORT:    sort_list();
            bole_pkg::OP_INSERT_SORT: begin
                if (full) r.st = bole_pkg::ST_FULL;
                else begin
                    sort_list();
                    k = 0;
                    while (k < n && $signed(list_q[k]) < $signed(v)) k++;
                    list_q.insert(k, v);
                end
            end
            bole_pkg::OP_EVENS_FIRST: begin
                foreach (list_q[i]) if (list_q[i][0]) od.push_back(list_q[i]);
                                    else ev.push_back(list_q[i]);
                list_q = {ev, od};
            end
            default: ;
        endcase
        r.cnt = bole_pkg::POS_W'(list_q.size());
        return r;
    endfunction

    // Drive one command and wait for its acceptance; valid stays up when no gap follows
    task automatic send_cmd(input logic [bole_pkg::OPCODE_W-1:0] op,
                            input logic [bole_pkg::DATA_W-1:0] v,
                            input logic [bole_pkg::POS_W-1:0] pos);
        int gap;
        gap = (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5));
        if (gap != 0) begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_ch.valid    <= 1'b1;
        cmd_ch.opcode   <= op;
        cmd_ch.value    <= v;
        cmd_ch.position <= pos;
        do @(posedge i_clk); while (!cmd_ch.ready);
    endtask

    // Predict at acceptance so expectations follow command order
    always @(posedge i_clk) begin
        if (i_rst_n && cmd_ch.valid && cmd_ch.ready)
            pending_q.push_back(list_apply(cmd_ch.opcode, cmd_ch.value, cmd_ch.position));
    end

    // Check each response against the oldest expectation
    always @(posedge i_clk) begin
        t_rsp exp_r;
        t_row trow;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (pending_q.size() == 0) report("response with nothing expected");
            else begin
                exp_r = pending_q.pop_front();
                if (typed_q.size() != 0) begin
                    trow = typed_q.pop_front();
                    if (trow.typed && trow.want != exp_r)
                        report($sformatf("table row disagrees on op %0d", trow.op));
                end
                if (rsp_ch.value_out !== exp_r.vout)
                    report($sformatf("value_out %h want %h", rsp_ch.value_out, exp_r.vout));
                if (rsp_ch.index_out !== exp_r.idx)
                    report($sformatf("index_out %0d want %0d", rsp_ch.index_out, exp_r.idx));
                if (rsp_ch.status !== exp_r.st)
                    report($sformatf("status %0d want %0d", rsp_ch.status, exp_r.st));
                if (rsp_ch.count !== exp_r.cnt)
                    report($sformatf("count %0d want %0d", rsp_ch.count, exp_r.cnt));
            end
        end
    end

    // After each taken item, hold the response ready low until a random wait count runs out
    always @(posedge i_clk) begin
        int unsigned w;
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
            rsp_wait     <= 0;
        end else if (rsp_ch.valid && rsp_ch.ready) begin
            w = $urandom_range(0, 5);
            rsp_wait     <= w;
            rsp_ch.ready <= (w == 0);
        end else if (rsp_wait > 1) begin
            rsp_wait <= rsp_wait - 1;
        end else begin
            rsp_wait     <= 0;
            rsp_ch.ready <= 1'b1;
        end
    end

    // Watchdog: cycles in which nothing is accepted
    always @(posedge i_clk) begin
        if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic t_row mk(input bole_pkg::t_op op,
                                input logic [bole_pkg::DATA_W-1:0] v,
                                input logic [bole_pkg::POS_W-1:0] pos, input bit typed,
                                input logic [bole_pkg::DATA_W-1:0] vo,
                                input logic [bole_pkg::POS_W-1:0] ix,
                                input bole_pkg::t_status st,
                                input logic [bole_pkg::POS_W-1:0] cnt);
        t_row r;
        r.op = op; r.val = v; r.pos = pos; r.typed = typed;
        r.want.vout = vo; r.want.idx = ix; r.want.st = st; r.want.cnt = cnt;
        return r;
    endfunction

    function automatic logic [bole_pkg::DATA_W-1:0] rnd_value(input int span);
        case ($urandom_range(0, 3))
            0:       return $urandom_range(0, span) - span / 2;
            1:       return {$urandom_range(0, 1) ? 1'b1 : 1'b0, 31'h7fffffff} ^
                            $urandom_range(0, 3);
            default: return $urandom();
        endcase
    endfunction

    initial begin
        int sz;
        logic [bole_pkg::OPCODE_W-1:0] op;
        logic [bole_pkg::POS_W-1:0] pos;
        logic [bole_pkg::DATA_W-1:0] v;
        cmd_ch.valid = 1'b0;
        cmd_ch.opcode = '0;
        cmd_ch.value = '0;
        cmd_ch.position = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table: empty-list errors, extremes, every command
        rows.push_back(mk(bole_pkg::OP_POP_FRONT,    0, 0, 1, 0, 0, bole_pkg::ST_EMPTY, 0));
        rows.push_back(mk(bole_pkg::OP_POP_BACK,     0, 0, 1, 0, 0, bole_pkg::ST_EMPTY, 0));
        rows.push_back(mk(bole_pkg::OP_DELETE_AT,    0, 0, 1, 0, 0, bole_pkg::ST_EMPTY, 0));
        rows.push_back(mk(bole_pkg::OP_DELETE_VALUE, 5, 0, 1, 0, 0, bole_pkg::ST_EMPTY, 0));
        rows.push_back(mk(bole_pkg::OP_DELETE_MAX,   0, 0, 1, 0, 0, bole_pkg::ST_EMPTY, 0));
        rows.push_back(mk(bole_pkg::OP_FIND,      5, 0, 1, 0, 0, bole_pkg::ST_NOTFOUND, 0));
        rows.push_back(mk(bole_pkg::OP_INSERT_AT, 7, 1, 1, 0, 0, bole_pkg::ST_BADPOS, 0));
        rows.push_back(mk(bole_pkg::OP_PUSH_FRONT, 32'h8000_0000, 0, 1, 0, 0,
                          bole_pkg::ST_OK, 1));
        rows.push_back(mk(bole_pkg::OP_PUSH_BACK, 32'h7fff_ffff, 0, 1, 0, 0,
                          bole_pkg::ST_OK, 2));
        rows.push_back(mk(bole_pkg::OP_INSERT_AT, 32'hffff_ffff, 2, 1, 0, 0,
                          bole_pkg::ST_OK, 3));
        rows.push_back(mk(bole_pkg::OP_INSERT_AT, 4, 1, 0, 0, 0, bole_pkg::ST_OK, 0));
        rows.push_back(mk(bole_pkg::OP_PUSH_BACK, 32'h7fff_ffff, 0, 0, 0, 0,
                          bole_pkg::ST_OK, 0));
        rows.push_back(mk(bole_pkg::OP_DELETE_AT, 0, 63, 1, 0, 0, bole_pkg::ST_BADPOS, 5));
        rows.push_back(mk(bole_pkg::OP_FIND, 32'h7fff_ffff, 0, 0, 0, 0, bole_pkg::ST_OK, 0));
        rows.push_back(mk(bole_pkg::OP_DELETE_VALUE, 9, 0, 0, 0, 0, bole_pkg::ST_OK, 0));
        rows.push_back(mk(bole_pkg::OP_EVENS_FIRST, 0, 0, 0, 0, 0, bole_pkg::ST_OK, 0));
        rows.push_back(mk(bole_pkg::OP_REVERSE,     0, 0, 0, 0, 0, bole_pkg::ST_OK, 0));
        rows.push_back(mk(bole_pkg::OP_SORT,        0, 0, 0, 0, 0, bole_pkg::ST_OK, 0));
        rows.push_back(mk(bole_pkg::OP_INSERT_SORT, 4, 0, 0, 0, 0, bole_pkg::ST_OK, 0));
        rows.push_back(mk(bole_pkg::OP_DELETE_MAX,  0, 0, 0, 0, 0, bole_pkg::ST_OK, 0));
        rows.push_back(mk(bole_pkg::OP_DELETE_AT,   0, 2, 0, 0, 0, bole_pkg::ST_OK, 0));
        rows.push_back(mk(bole_pkg::OP_POP_BACK,    0, 0, 0, 0, 0, bole_pkg::ST_OK, 0));
        rows.push_back(mk(bole_pkg::OP_POP_FRONT,   0, 0, 0, 0, 0, bole_pkg::ST_OK, 0));
        rows.push_back(mk(bole_pkg::t_op'(4'd15),   0, 0, 1, 0, 0, bole_pkg::ST_OK, 2));
        foreach (rows[i]) begin
            typed_q.push_back(rows[i]);
            send_cmd(rows[i].op, rows[i].val, rows[i].pos);
        end

        // Fill to capacity, then hit the full-list cases
        while (list_q.size() < CAP) begin
            typed_q.push_back(mk(bole_pkg::OP_PUSH_BACK, 0, 0, 0, 0, 0, bole_pkg::ST_OK, 0));
            send_cmd(bole_pkg::OP_PUSH_BACK, $urandom_range(0, 20) - 10, 0);
        end
        for (int i = 0; i < 4; i++) begin
            op = (i == 0) ? bole_pkg::OP_PUSH_FRONT : (i == 1) ? bole_pkg::OP_INSERT_AT :
                 (i == 2) ? bole_pkg::OP_INSERT_SORT : bole_pkg::OP_INSERT_AT;
            pos = (i == 3) ? 6'd33 : 6'd32;
            typed_q.push_back(mk(bole_pkg::t_op'(op), 0, 0, 0, 0, 0, bole_pkg::ST_OK, 0));
            send_cmd(op, 1, pos);
        end
        typed_q.delete();

        // Random part: bias toward a mid-size list with repeated values
        for (int n = 0; n < 1000; n++) begin
            sz = list_q.size();
            case ($urandom_range(0, 9))
                0, 1, 2: op = bole_pkg::OPCODE_W'($urandom_range(bole_pkg::OP_PUSH_FRONT,
                                                                 bole_pkg::OP_INSERT_AT));
                3:       op = bole_pkg::OP_INSERT_SORT;
                4, 5:    op = bole_pkg::OPCODE_W'($urandom_range(bole_pkg::OP_POP_FRONT,
                                                                 bole_pkg::OP_DELETE_MAX));
                6:       op = bole_pkg::OP_FIND;
                7:       op = bole_pkg::OPCODE_W'($urandom_range(bole_pkg::OP_REVERSE,
                                                                 bole_pkg::OP_EVENS_FIRST));
                8:       op = (sz > 20) ? bole_pkg::OP_POP_FRONT : bole_pkg::OP_PUSH_BACK;
                default: op = bole_pkg::OPCODE_W'($urandom_range(0, 15));
            endcase
            if ((op == bole_pkg::OP_DELETE_VALUE || op == bole_pkg::OP_FIND) && sz > 0 &&
                $urandom_range(0, 1))
                v = list_q[$urandom_range(0, sz - 1)];
            else
                v = rnd_value(40);
            pos = ($urandom_range(0, 7) == 0) ? bole_pkg::POS_W'($urandom()) :
                                                bole_pkg::POS_W'($urandom_range(0, sz + 1));
            send_cmd(op, v, pos);
        end
        cmd_ch.valid <= 1'b0;
        stim_done = 1;

        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (n_fail == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
